/* hw/rtl/polygon_edge_crossing_check_top_macros.svh */
// assertion macros for the checker file
`ifndef POLYGON_EDGE_CROSSING_CHECK_TOP_MACROS_SVH
`define POLYGON_EDGE_CROSSING_CHECK_TOP_MACROS_SVH

// same-cycle implication, held off during reset
`define PECC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, held off during reset
`define PECC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/pecc_pkg.sv */
// shared constants and sequencer state type for the edge crossing check
package pecc_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_READ,
    ST_DIFF,
    ST_CROSS_D,
    ST_CROSS_T,
    ST_CROSS_U,
    ST_EVAL,
    ST_DONE
  } state_t;

endpackage

/* hw/rtl/polygon_edge_crossing_check_top.sv */
// top level: point loop stores, pair sequencer and crossing decision
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  command  | start, busy        | cmd, point_x, point_y, last_point
//  result   | done (1-cycle)     | overlap, overflow
//
// a point transaction is taken when start is seen while idle; a last second-loop point
// starts a check. the check runs one shared cross-product unit, stepping each edge pair
// through read, diff, three cross-product steps and eval, and stops early on a hit,
// then the done cycle. after a check-starting transaction busy stays high until the
// done cycle ends. reset is synchronous and clears counts and flags, not the point stores.
// the receiver cannot stall: done is shown for exactly one cycle.
module polygon_edge_crossing_check_top #(
  parameter int MAX_POINTS = pecc_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = pecc_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         cmd,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic                         last_point,
  output logic                         done,
  output logic                         overlap,
  output logic                         overflow
);

  localparam int CB = COORD_BITS;
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int DW = CB + 1;
  localparam int PW = 2 * DW + 1;

  pecc_pkg::state_t state, state_next;

  logic [2*CB-1:0] first_mem  [MAX_POINTS];
  logic [2*CB-1:0] second_mem [MAX_POINTS];

  logic [CW-1:0] n1, n2;
  logic          dropped;
  logic          hit;
  logic [AW-1:0] i, j;
  logic [AW-1:0] i1, j1;
  logic          i_last, j_last;

  logic [2*CB-1:0] s0, s1, f0, f1;
  logic signed [DW-1:0] dx12, dy12, dx34, dy34, dx13, dy13;
  logic signed [DW-1:0] op_a, op_b, op_c, op_e;
  logic signed [PW-1:0] xr, d_reg, tn_reg;

  logic accept;
  logic first_full, second_full;
  logic counts_zero;
  logic pair_cross;
  logic d_pos;
  logic tn_ok, un_ok;

  assign first_full  = (n1 == CW'(MAX_POINTS));
  assign second_full = (n2 == CW'(MAX_POINTS));
  assign counts_zero = (n1 == '0) || (n2 == '0);

  assign i_last = ((CW'(i) + CW'(1)) == n2);
  assign j_last = ((CW'(j) + CW'(1)) == n1);
  assign i1     = i_last ? '0 : i + AW'(1);
  assign j1     = j_last ? '0 : j + AW'(1);

  // point stores, two registered read ports each
  always_ff @(posedge clk) begin
    if (accept && !cmd && !first_full) begin
      first_mem[n1[AW-1:0]] <= {point_x, point_y};
    end
    if (accept && cmd && !second_full) begin
      second_mem[n2[AW-1:0]] <= {point_x, point_y};
    end
    s0 <= second_mem[i];
    s1 <= second_mem[i1];
    f0 <= first_mem[j];
    f1 <= first_mem[j1];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pecc_pkg::ST_IDLE: begin
        if (accept && cmd && last_point) state_next = pecc_pkg::ST_START;
      end
      pecc_pkg::ST_START: begin
        state_next = counts_zero ? pecc_pkg::ST_DONE : pecc_pkg::ST_READ;
      end
      pecc_pkg::ST_READ:    state_next = pecc_pkg::ST_DIFF;
      pecc_pkg::ST_DIFF:    state_next = pecc_pkg::ST_CROSS_D;
      pecc_pkg::ST_CROSS_D: state_next = pecc_pkg::ST_CROSS_T;
      pecc_pkg::ST_CROSS_T: state_next = pecc_pkg::ST_CROSS_U;
      pecc_pkg::ST_CROSS_U: state_next = pecc_pkg::ST_EVAL;
      pecc_pkg::ST_EVAL: begin
        if (pair_cross || (i_last && j_last)) state_next = pecc_pkg::ST_DONE;
        else                                  state_next = pecc_pkg::ST_READ;
      end
      pecc_pkg::ST_DONE:    state_next = pecc_pkg::ST_IDLE;
      default:              state_next = pecc_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy = 1'b1;
    done = 1'b0;
    op_a = dx12;
    op_b = dy34;
    op_c = dy12;
    op_e = dx34;
    unique case (state)
      pecc_pkg::ST_IDLE: busy = 1'b0;
      pecc_pkg::ST_CROSS_T: begin
        op_a = dx13;
        op_b = dy34;
        op_c = dy13;
        op_e = dx34;
      end
      pecc_pkg::ST_CROSS_U: begin
        op_a = dy12;
        op_b = dx13;
        op_c = dx12;
        op_e = dy13;
      end
      pecc_pkg::ST_DONE: done = 1'b1;
      default: ;
    endcase
  end

  assign accept   = start && !busy;
  assign overlap  = hit;
  assign overflow = dropped;

  pecc_xprod_unit #(
    .W (DW)
  ) u_xprod (
    .clk (clk),
    .a   (op_a),
    .b   (op_b),
    .c   (op_c),
    .e   (op_e),
    .r   (xr)
  );

  // in the eval cycle xr holds un; t and u must both lie in the closed unit range
  assign d_pos      = !d_reg[PW-1];
  assign tn_ok      = d_pos ? (!tn_reg[PW-1] && (tn_reg <= d_reg))
                            : ((tn_reg <= 0) && (tn_reg >= d_reg));
  assign un_ok      = d_pos ? (!xr[PW-1] && (xr <= d_reg))
                            : ((xr <= 0) && (xr >= d_reg));
  assign pair_cross = (d_reg != '0) && tn_ok && un_ok;

  // edge differences and partial results
  always_ff @(posedge clk) begin
    if (state == pecc_pkg::ST_DIFF) begin
      dx12 <= $signed({s0[2*CB-1], s0[2*CB-1:CB]}) - $signed({s1[2*CB-1], s1[2*CB-1:CB]});
      dy12 <= $signed({s0[CB-1], s0[CB-1:0]}) - $signed({s1[CB-1], s1[CB-1:0]});
      dx34 <= $signed({f0[2*CB-1], f0[2*CB-1:CB]}) - $signed({f1[2*CB-1], f1[2*CB-1:CB]});
      dy34 <= $signed({f0[CB-1], f0[CB-1:0]}) - $signed({f1[CB-1], f1[CB-1:0]});
      dx13 <= $signed({s0[2*CB-1], s0[2*CB-1:CB]}) - $signed({f0[2*CB-1], f0[2*CB-1:CB]});
      dy13 <= $signed({s0[CB-1], s0[CB-1:0]}) - $signed({f0[CB-1], f0[CB-1:0]});
    end
    if (state == pecc_pkg::ST_CROSS_T) d_reg  <= xr;
    if (state == pecc_pkg::ST_CROSS_U) tn_reg <= xr;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= pecc_pkg::ST_IDLE;
      n1      <= '0;
      n2      <= '0;
      dropped <= 1'b0;
      hit     <= 1'b0;
      i       <= '0;
      j       <= '0;
    end else begin
      state <= state_next;
      case (state)
        pecc_pkg::ST_IDLE: begin
          if (accept) begin
            if (!cmd) begin
              if (first_full) dropped <= 1'b1;
              else            n1 <= n1 + CW'(1);
            end else begin
              if (second_full) dropped <= 1'b1;
              else             n2 <= n2 + CW'(1);
            end
          end
        end
        pecc_pkg::ST_START: begin
          hit <= 1'b0;
          i   <= '0;
          j   <= '0;
        end
        pecc_pkg::ST_EVAL: begin
          if (pair_cross) begin
            hit <= 1'b1;
          end else if (j_last) begin
            j <= '0;
            i <= i1;
          end else begin
            j <= j1;
          end
        end
        pecc_pkg::ST_DONE: begin
          n1      <= '0;
          n2      <= '0;
          dropped <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/pecc_xprod_unit.sv */
// shared cross-product unit: registered a*b - c*e
module pecc_xprod_unit #(
  parameter int W = pecc_pkg::COORD_BITS_DEF + 1
) (
  input  logic                clk,
  input  logic signed [W-1:0] a,
  input  logic signed [W-1:0] b,
  input  logic signed [W-1:0] c,
  input  logic signed [W-1:0] e,
  output logic signed [2*W:0] r
);

  logic signed [2*W-1:0] p0;
  logic signed [2*W-1:0] p1;

  assign p0 = a * b;
  assign p1 = c * e;

  always_ff @(posedge clk) begin
    r <= {p0[2*W-1], p0} - {p1[2*W-1], p1};
  end

endmodule

/* hw/rtl/pecc_checker.sv */
// port-level checker for the edge crossing check, bound to the top level
`include "polygon_edge_crossing_check_top_macros.svh"

module pecc_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic cmd,
  input logic last_point,
  input logic done
);

  logic start_check;
  logic plain_point;

  assign start_check = start && !busy && cmd && last_point;
  assign plain_point = start && !busy && !(cmd && last_point);

  `PECC_ASSERT_NOW(a_done_busy, clk, rst, done, busy, "result strobe while idle")
  `PECC_ASSERT_NEXT(a_check_busy, clk, rst, start_check, busy, "check did not start")
  `PECC_ASSERT_NEXT(a_point_quiet, clk, rst, plain_point, !done && !busy, "result after point")
  `PECC_ASSERT_NEXT(a_done_once, clk, rst, done, !done && !busy, "result strobe not single")

endmodule

bind polygon_edge_crossing_check_top pecc_checker u_pecc_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .cmd        (cmd),
  .last_point (last_point),
  .done       (done)
);
